/* rtl/vdg_pkg.sv */
`timescale 1ns / 1ps

package vdg_pkg;

   // Default grid and list sizes
   localparam int DIM_X_DEFAULT      = 32;
   localparam int DIM_Y_DEFAULT      = 32;
   localparam int DIM_Z_DEFAULT      = 32;
   localparam int LIST_DEPTH_DEFAULT = 32768;

   // Request codes
   localparam logic [1:0] OP_OCCUPY = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_LIST   = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic signed [15:0] cell_z;
      logic signed [31:0] sample_value;
      logic [14:0]        list_index;
   } vdg_req_type;

   typedef struct packed {
      logic signed [31:0] cell_value;
      logic               in_grid;
      logic               newly_listed;
      logic               list_full;
      logic [15:0]        list_count;
      logic [4:0]         entry_x;
      logic [4:0]         entry_y;
      logic [4:0]         entry_z;
   } vdg_rsp_type;

endpackage

/* rtl/vdg_req_if.sv */
`timescale 1ns / 1ps

interface vdg_req_if;
   import vdg_pkg::*;

   logic        valid;
   logic        ready;
   vdg_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/vdg_rsp_if.sv */
`timescale 1ns / 1ps

interface vdg_rsp_if;
   import vdg_pkg::*;

   logic        valid;
   logic        ready;
   vdg_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/voxel_density_grid.sv */
`timescale 1ns / 1ps

// Cell requests and list reads past the count go from ST_IDLE to ST_CELL; a live list read
// passes through ST_LIST first. ST_CELL holds while the result register is full and not taken.
// A new request is taken only in ST_IDLE, once the last result is registered. An in-grid
// request reads the cell RAM (after the list RAM for live list reads); an occupy or add
// writes it back. Reset (synchronous): clears the list count, then sweeps the cell RAM
// to zero one cell per cycle, DIM_X*DIM_Y*DIM_Z cells (32768 by default), ready held low.
module voxel_density_grid #(
   parameter int DIM_X      = vdg_pkg::DIM_X_DEFAULT,
   parameter int DIM_Y      = vdg_pkg::DIM_Y_DEFAULT,
   parameter int DIM_Z      = vdg_pkg::DIM_Z_DEFAULT,
   parameter int LIST_DEPTH = vdg_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   vdg_req_if.sink   req_chan,
   vdg_rsp_if.source rsp_chan
);
   import vdg_pkg::*;

   // Sizes
   localparam int CELLS = DIM_X * DIM_Y * DIM_Z;
   localparam int CW    = $clog2(CELLS);          // cell address
   localparam int XW    = $clog2(DIM_X);
   localparam int YW    = $clog2(DIM_Y);
   localparam int ZW    = $clog2(DIM_Z);
   localparam int LDW   = XW + YW + ZW;           // list entry: packed coordinates
   localparam int LW    = $clog2(LIST_DEPTH);     // list address
   localparam int NW    = $clog2(LIST_DEPTH + 1); // list count

   // One-hot sequencer
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,  // reset sweep of the cell RAM
      ST_IDLE  = 4'b0010,  // waiting for a request
      ST_LIST  = 4'b0100,  // list entry out of RAM, cell read issued
      ST_CELL  = 4'b1000   // cell out of RAM, modify and write back
   } state_type;

   // Row-major cell address, x slowest, z fastest
   function automatic logic [CW-1:0] cell_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y,
                                               input logic [ZW-1:0] z);
      logic [CW-1:0] row;
      row = CW'(x) * CW'(DIM_Y) + CW'(y);
      return row * CW'(DIM_Z) + CW'(z);
   endfunction

   // Registers
   state_type   state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [NW-1:0] count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] sample_ff, sample_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic [ZW-1:0] cz_ff, cz_in;
   logic        hit_ff, hit_in;      // a grid cell is named
   logic        rsp_valid_ff, rsp_valid_in;
   vdg_rsp_type rsp_ff, rsp_in;

   // RAM ports
   logic          cell_wr_en, cell_rd_en;
   logic [CW-1:0] cell_wr_addr, cell_rd_addr;
   logic [31:0]   cell_wr_data, cell_rd_data;
   logic          list_wr_en, list_rd_en;
   logic [LW-1:0] list_wr_addr, list_rd_addr;
   logic [LDW-1:0] list_wr_data, list_rd_data;

   // Request decode
   vdg_req_type   rq;
   logic          req_fire;
   logic          req_in_grid;
   logic [XW-1:0] rq_x;
   logic [YW-1:0] rq_y;
   logic [ZW-1:0] rq_z;
   logic          list_hit;

   // List entry decode
   logic [XW-1:0] le_x;
   logic [YW-1:0] le_y;
   logic [ZW-1:0] le_z;

   // Modify
   logic          rsp_load;
   logic          is_write;
   logic          was_zero;
   logic          need_append;
   logic          list_room;
   logic [32:0]   sum_wide;
   logic [31:0]   sum_sat;
   logic [31:0]   new_value;

   assign rq       = req_chan.payload;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign req_in_grid = !rq.cell_x[15] && (rq.cell_x < 16'(DIM_X)) &&
                        !rq.cell_y[15] && (rq.cell_y < 16'(DIM_Y)) &&
                        !rq.cell_z[15] && (rq.cell_z < 16'(DIM_Z));
   assign rq_x = XW'(rq.cell_x);
   assign rq_y = YW'(rq.cell_y);
   assign rq_z = ZW'(rq.cell_z);

   // Index below the count, so it is also a valid list address
   assign list_hit = (32'(rq.list_index) < 32'(count_ff));

   assign {le_x, le_y, le_z} = list_rd_data;

   // Read-modify-write arithmetic on the cell read in ST_CELL
   assign is_write    = hit_ff && (op_ff inside {OP_OCCUPY, OP_ADD});
   assign was_zero    = (cell_rd_data == 32'd0);
   assign need_append = is_write && was_zero;
   assign list_room   = (count_ff != NW'(LIST_DEPTH));
   assign sum_wide    = {cell_rd_data[31], cell_rd_data} + {sample_ff[31], sample_ff};

   // Overflow when the two top bits of the 33-bit sum differ
   always_comb begin
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         sum_sat = sum_wide[31:0];
      end
   end

   always_comb begin
      case (op_ff)
         OP_OCCUPY: new_value = was_zero ? sample_ff : cell_rd_data;
         OP_ADD:    new_value = sum_sat;
         default:   new_value = cell_rd_data;
      endcase
   end

   // Result goes out once the output register is free
   assign rsp_load = (state_ff == ST_CELL) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      sample_in    = sample_ff;
      addr_in      = addr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;

      cell_wr_en   = 1'b0;
      cell_wr_addr = addr_ff;
      cell_wr_data = new_value;
      cell_rd_en   = 1'b0;
      cell_rd_addr = cell_addr(rq_x, rq_y, rq_z);
      list_wr_en   = 1'b0;
      list_wr_addr = count_ff[LW-1:0];
      list_wr_data = {cx_ff, cy_ff, cz_ff};
      list_rd_en   = 1'b0;
      list_rd_addr = LW'(rq.list_index);

      case (state_ff)
         ST_CLEAR: begin
            cell_wr_en   = 1'b1;
            cell_wr_addr = clr_ff;
            cell_wr_data = 32'd0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == CW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = rq.req_type;
               sample_in = rq.sample_value;
               cx_in     = rq_x;
               cy_in     = rq_y;
               cz_in     = rq_z;
               addr_in   = cell_addr(rq_x, rq_y, rq_z);
               if (rq.req_type == OP_LIST) begin
                  hit_in     = 1'b0;
                  list_rd_en = list_hit;
                  state_in   = list_hit ? ST_LIST : ST_CELL;
               end else begin
                  hit_in     = req_in_grid;
                  cell_rd_en = req_in_grid;
                  state_in   = ST_CELL;
               end
            end
         end
         ST_LIST: begin
            // Entry holds coordinates; rebuild the cell address from them
            cell_rd_addr = cell_addr(le_x, le_y, le_z);
            cell_rd_en   = 1'b1;
            addr_in      = cell_rd_addr;
            cx_in        = le_x;
            cy_in        = le_y;
            cz_in        = le_z;
            hit_in       = 1'b1;
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            if (rsp_load) begin
               cell_wr_en = is_write;
               list_wr_en = need_append && list_room;
               if (list_wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               rsp_in.cell_value   = hit_ff ? new_value : 32'd0;
               rsp_in.in_grid      = hit_ff;
               rsp_in.newly_listed = list_wr_en;
               rsp_in.list_full    = need_append && !list_room;
               rsp_in.list_count   = 16'(count_in);
               if (hit_ff && (op_ff == OP_LIST)) begin
                  rsp_in.entry_x = 5'(cx_ff);
                  rsp_in.entry_y = 5'(cy_ff);
                  rsp_in.entry_z = 5'(cz_ff);
               end else begin
                  rsp_in.entry_x = 5'd0;
                  rsp_in.entry_y = 5'd0;
                  rsp_in.entry_z = 5'd0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      sample_ff <= sample_in;
      addr_ff   <= addr_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Cell store. Write-back lands before the next request can read, so no bypass.
   vdg_ram #(
      .WIDTH (32),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   // Occupied list, packed coordinates
   vdg_ram #(
      .WIDTH (LDW),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

`ifndef ASSERT_OFF
   // Count never passes the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(LIST_DEPTH))
      else $error("list count beyond depth");

   // An append raises the count by exactly one
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      list_wr_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not advance count");

   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("pending result overwritten");

   // An accepted request always moves the sequencer out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted without work");
`endif

endmodule

/* rtl/vdg_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one registered read port.
module vdg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/vdg_tb_pkg.sv */
`timescale 1ns / 1ps

package vdg_tb_pkg;
   import vdg_pkg::*;

   localparam int GX         = DIM_X_DEFAULT;
   localparam int GY         = DIM_Y_DEFAULT;
   localparam int GZ         = DIM_Z_DEFAULT;
   localparam int GRID_CELLS = GX * GY * GZ;
   localparam int LIST_CAP   = LIST_DEPTH_DEFAULT;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -Q_MAX - 1;

   // Shadow copy of the density grid and its occupied list, plus the
   // responses still owed by the block.
   class grid_shadow;
      int          density [GRID_CELLS];
      int unsigned occupied [LIST_CAP];
      int unsigned list_len;
      vdg_rsp_type pending_answers [$];
      int          errors;
      int          checked;
      int          op_seen [4];
      int          refused;
      int          clipped;
      int          off_grid;

      // Apply one accepted request to the shadow state, queue its response.
      function void take_request(vdg_req_type r);
         vdg_rsp_type want;
         int          x, y, z;
         int unsigned p;
         int          old_v;
         longint      acc;
         want = '0;
         x = $signed(r.cell_x);
         y = $signed(r.cell_y);
         z = $signed(r.cell_z);
         op_seen[r.req_type]++;
         if (r.req_type == OP_LIST) begin
            // only entries below the count are ever looked at
            if (r.list_index < list_len) begin
               p = occupied[r.list_index];
               want.entry_x    = 5'(p / (GY * GZ));
               want.entry_y    = 5'((p / GZ) % GY);
               want.entry_z    = 5'(p % GZ);
               want.cell_value = density[p];
               want.in_grid    = 1'b1;
            end
         end else if (x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ) begin
            p = (x * GY + y) * GZ + z;
            old_v = density[p];
            want.in_grid = 1'b1;
            if (r.req_type != OP_READ && old_v == 0) begin
               if (list_len < LIST_CAP) begin
                  occupied[list_len] = p;
                  list_len++;
                  want.newly_listed = 1'b1;
               end else begin
                  want.list_full = 1'b1;
                  refused++;
               end
            end
            if (r.req_type == OP_OCCUPY && old_v == 0) begin
               density[p] = r.sample_value;
            end else if (r.req_type == OP_ADD) begin
               acc = longint'(old_v) + longint'($signed(r.sample_value));
               if (acc > Q_MAX) begin
                  acc = Q_MAX;
                  clipped++;
               end else if (acc < Q_MIN) begin
                  acc = Q_MIN;
                  clipped++;
               end
               density[p] = int'(acc);
            end
            want.cell_value = density[p];
         end else begin
            off_grid++;
         end
         want.list_count = 16'(list_len);
         pending_answers = {pending_answers, want};
      endfunction

      function void same(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      // Compare one accepted response against the oldest one owed.
      function void match_response(vdg_rsp_type got);
         vdg_rsp_type want;
         if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t ns: response with no request outstanding, got %0h", $time, got);
            return;
         end
         want = pending_answers.pop_front();
         checked++;
         same("cell_value", want.cell_value, got.cell_value);
         same("in_grid", want.in_grid, got.in_grid);
         same("newly_listed", want.newly_listed, got.newly_listed);
         same("list_full", want.list_full, got.list_full);
         same("list_count", want.list_count, got.list_count);
         same("entry_x", want.entry_x, got.entry_x);
         same("entry_y", want.entry_y, got.entry_y);
         same("entry_z", want.entry_z, got.entry_z);
      endfunction
   endclass

endpackage

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import vdg_pkg::*;
   import vdg_tb_pkg::*;

   // Run time is dominated by the clearing sweep after reset (one cell per
   // cycle) and by the idle gaps and receiver stalls between requests; the
   // limit is several times the slowest legal run with every gap at its longest.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int LONG_HOLD     = 300;   // receiver hold-off, cycles
   localparam int RANDOM_ITEMS  = 560;
   localparam int TAIL_ITEMS    = 100;   // random requests sent flat out at the end
   localparam int SETTLE_CYCLES = 6;     // settle after the drain, with margin

   logic clock = 1'b0;
   logic reset;

   vdg_req_if req_chan ();
   vdg_rsp_if rsp_chan ();

   voxel_density_grid dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   grid_shadow shadow;

   bit no_idle = 1'b0;     // both sides run flat out while set
   int holds_asked;        // bumped by the stimulus to ask for a long hold-off
   int holds_served;
   int cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d responses still owed",
                  CYCLE_LIMIT, shadow.pending_answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Idle stretch: nine draws in ten from the low range, the rest from the high one.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // One coordinate: mostly a small corner of the grid so that cells are hit
   // repeatedly, some spread over the whole axis, a few off the grid.
   function automatic logic [15:0] pick_axis(int dim);
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 3)
         return 16'($urandom());
      if (k < 5)
         return 16'hFFFF;                 // one below the grid
      if (k < 7)
         return 16'(dim);                 // one past the grid
      if (k < 8)
         return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      if (k < 35)
         return 16'($urandom_range(0, dim - 1));
      return 16'($urandom_range(0, 3));
   endfunction

   function automatic vdg_req_type make_request(logic [1:0] op, int x, int y, int z,
                                                logic [31:0] v, logic [14:0] idx);
      vdg_req_type r;
      r.req_type     = op;
      r.cell_x       = 16'(x);
      r.cell_y       = 16'(y);
      r.cell_z       = 16'(z);
      r.sample_value = v;
      r.list_index   = idx;
      return r;
   endfunction

   function automatic vdg_req_type random_request();
      vdg_req_type r;
      int unsigned k;
      k = $urandom_range(0, 99);
      r.req_type = (k < 25) ? OP_OCCUPY : (k < 60) ? OP_ADD : (k < 78) ? OP_READ : OP_LIST;
      r.cell_x = pick_axis(GX);
      r.cell_y = pick_axis(GY);
      r.cell_z = pick_axis(GZ);
      // sample: zero, small of either sign, close to the Q16.16 limits, or anything
      k = $urandom_range(0, 99);
      if (k < 10) begin
         r.sample_value = '0;
      end else if (k < 45) begin
         r.sample_value = $urandom_range(0, 32'h0003_0000);
         if ($urandom_range(0, 1))
            r.sample_value = -r.sample_value;
      end else if (k < 65) begin
         r.sample_value = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000)
                          | $urandom_range(0, 16'hFFFF);
      end else begin
         r.sample_value = $urandom();
      end
      // list position: mostly a live entry, sometimes just past the end or anywhere
      k = $urandom_range(0, 99);
      if (k < 70 && shadow.list_len > 0)
         r.list_index = 15'($urandom_range(0, shadow.list_len - 1));
      else if (k < 80)
         r.list_index = 15'(shadow.list_len);
      else
         r.list_index = 15'($urandom());
      return r;
   endfunction

   // Offer one request after an optional gap and wait for the block to take it.
   // Valid stays high between back-to-back requests.
   task automatic send_request(input vdg_req_type r);
      int gap;
      gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.payload <= r;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      shadow.take_request(r);
   endtask

   // Stop offering and wait until every owed response has come back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (shadow.pending_answers.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: random stalls of its own, plus a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
               stall_left = idle_len();
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         shadow.match_response(rsp_chan.payload);
   end

   initial begin
      int n;
      shadow = new();
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- Directed requests ---------------------------------------------
      // Fresh grid: a cell read gives zero, a list read on an empty list gives nothing.
      send_request(make_request(OP_READ, 0, 0, 0, 32'h0, 15'd0));
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'd0));
      // Largest positive sample into an empty cell, then an add that must clip.
      send_request(make_request(OP_OCCUPY, 0, 0, 0, 32'h7FFF_FFFF, 15'd0));
      send_request(make_request(OP_ADD, 0, 0, 0, 32'h7FFF_FFFF, 15'd0));
      // Occupy on a filled cell leaves it alone and does not list it.
      send_request(make_request(OP_OCCUPY, 0, 0, 0, 32'h0000_0005, 15'd0));
      // Far corner: most negative sample, clip low, then walk the sum back to zero.
      send_request(make_request(OP_OCCUPY, 31, 31, 31, 32'h8000_0000, 15'd0));
      send_request(make_request(OP_ADD, 31, 31, 31, 32'h8000_0000, 15'd0));
      send_request(make_request(OP_ADD, 31, 31, 31, 32'h7FFF_FFFF, 15'd0));
      send_request(make_request(OP_ADD, 31, 31, 31, 32'h0000_0001, 15'd0));
      // The cell is zero again, so this add lists it a second time.
      send_request(make_request(OP_ADD, 31, 31, 31, 32'h0001_0000, 15'd0));
      // Writing zero still lists the cell, and leaves it open for a later write.
      send_request(make_request(OP_OCCUPY, 1, 2, 3, 32'h0, 15'd0));
      send_request(make_request(OP_OCCUPY, 1, 2, 3, 32'h0001_8000, 15'd0));
      // Off the grid, then an in-grid read: writes change nothing, reads answer zero.
      send_request(make_request(OP_ADD, -1, 0, 0, 32'h0000_0001, 15'd0));
      send_request(make_request(OP_OCCUPY, 32, 0, 0, 32'h0000_0001, 15'd0));
      send_request(make_request(OP_READ, 0, -32768, 0, 32'h0, 15'd0));
      send_request(make_request(OP_READ, 0, 0, 32767, 32'h0, 15'd0));
      send_request(make_request(OP_READ, 31, 0, 0, 32'hFFFF_FFFF, 15'h7FFF));
      // List entries, the last live one, one past the end and the top index.
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'd1));
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'(shadow.list_len - 1)));
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'(shadow.list_len)));
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'h7FFF));
      send_request(make_request(OP_READ, 0, 0, 0, 32'h0, 15'd0));

      // ---- Random traffic ------------------------------------------------
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // Long receiver hold-off while requests keep coming: the block backs up.
         if (n == 200)
            holds_asked <= holds_asked + 1;
         // Sender pause until the block has answered everything.
         if (n == 350)
            drain();
         send_request(random_request());
      end

      // Spread cells: occupy, then step down, an add of the most negative sample, a zero write,
      // and list reads at the top index and the first entry.
      send_request(make_request(OP_OCCUPY, 17, 9, 26, 32'h0001_2345, 15'd0));
      send_request(make_request(OP_ADD, 17, 9, 26, 32'hFFFF_0000, 15'd0));
      send_request(make_request(OP_ADD, 22, 30, 4, 32'h8000_0000, 15'd0));
      send_request(make_request(OP_OCCUPY, 30, 30, 30, 32'h0, 15'd0));
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'h7FFF));
      send_request(make_request(OP_LIST, 0, 0, 0, 32'h0, 15'd0));

      // ---- Tail, flat out ------------------------------------------------
      no_idle <= 1'b1;
      for (n = 0; n < TAIL_ITEMS; n++)
         send_request(random_request());
      no_idle <= 1'b0;

      // ---- Wind down -----------------------------------------------------
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (shadow.pending_answers.size() != 0) begin
         shadow.errors++;
         $display("%0t ns: %0d responses never arrived", $time,
                  shadow.pending_answers.size());
      end
      $display("Sent %0d occupy, %0d add, %0d cell read and %0d list read requests;",
               shadow.op_seen[OP_OCCUPY], shadow.op_seen[OP_ADD], shadow.op_seen[OP_READ],
               shadow.op_seen[OP_LIST]);
      $display("%0d responses compared, list at %0d entries, %0d sums clipped, %0d off grid.",
               shadow.checked, shadow.list_len, shadow.clipped, shadow.off_grid);
      if (shadow.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
